// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds every cycle outside reset
`define SPALT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define SPALT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/spalt_pkg.sv -----
`timescale 1ns / 1ps
package spalt_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IN_W        = 424;
    localparam int OUT_W       = 176;

    localparam logic [21:0] BYTES_MAX   = 22'd4194303;
    localparam logic [36:0] DELAY_FLOOR = 37'd1000;
    localparam logic [61:0] GAP_BIAS    = 62'd2;

    localparam logic [2:0] OP_REC  = 3'd0;
    localparam logic [2:0] OP_ACK1 = 3'd1;
    localparam logic [2:0] OP_ACK2 = 3'd2;
    localparam logic [2:0] OP_SCAN = 3'd3;
    localparam logic [2:0] OP_DROP = 3'd4;

    localparam logic [2:0] KIND_ACKED = 3'd0;
    localparam logic [2:0] KIND_LOST  = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_FULL  = 3'd3;
    localparam logic [2:0] KIND_IGN   = 3'd4;

    localparam logic REG_RTT_MULT  = 1'b0;
    localparam logic REG_MIN_DELAY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP1, S_PREP2, S_PREP3, S_SCAN, S_EMIT, S_CLOSE
    } t_state;

    typedef struct packed {
        logic        cnt;
        logic [15:0] len;
        logic [61:0] tm;
        logic [61:0] num;
    } t_entry;

    function automatic logic [61:0] sat_sub(input logic [61:0] a, input logic [61:0] b);
        return (a > b) ? (a - b) : 62'd0;
    endfunction
endpackage

// ----- rtl/core/sent_packet_ack_loss_tracker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Sent-packet table: record, ACK-range retirement and time-threshold loss scan.
// Record, drop and unknown words are accepted, then answered with the closing word.
// An ACK next range or a loss scan passes setup states S_PREP1 to S_PREP3 (an ACK
// first range only S_PREP3), then one sweep of the table per retired packet and one
// final sweep. Each sweep reads all TABLE_DEPTH slots through the single read port
// of the entry RAM and is followed by the state that sends the retired or the
// closing word. Packets leave in ascending packet number, ties by slot.
// Each result word waits in one output register; a stalled output holds the sweep.
module sent_packet_ack_loss_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pkt_number, time_us, pkt_len, in_flight, smoothed_rtt, largest_acked,
    // first_span, range_gap, range_len, zero pad
    input  logic [spalt_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic [2:0]                    s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_pkt_number, out_pkt_len, out_in_flight, unacked_bytes, loss_deadline,
    // packets_tracked, zero pad
    output logic [spalt_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic [2:0]                    m_axis_tuser,   // kind
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [31:0]                   i_cfg_wdata
);
    import spalt_pkg::*;

    t_state r_state, n_state;

    logic [4:0]  r_mult;
    logic [31:0] r_min;

    logic [2:0]  r_op;
    logic [61:0] r_hi, r_lo, r_arg, r_len_arg, r_now, r_cursor;
    logic [31:0] r_rtt;
    logic [36:0] r_prod, r_delay;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_tracked;
    logic [21:0]            r_unacked;
    logic [62:0]            r_earliest;
    logic                   r_dropped;

    logic [CNT_W-1:0]  r_idx;
    logic              r_chk;
    logic [SLOT_W-1:0] r_chk_slot;
    logic              r_have;
    logic [SLOT_W-1:0] r_best_slot;
    logic [61:0]       r_best_num;
    logic [15:0]       r_best_len;
    logic              r_best_cnt;
    logic              r_first_pass;
    logic              r_dl_have;
    logic [62:0]       r_dl_best;
    logic [2:0]        r_close_kind;

    logic        r_ov;
    logic [2:0]  r_o_kind;
    logic [61:0] r_o_num;
    logic [15:0] r_o_len;
    logic        r_o_infl;
    logic [21:0] r_o_unacked;
    logic [62:0] r_o_deadline;
    logic [CNT_W-1:0] r_o_tracked;
    logic        r_o_last;

    // input fields
    logic [2:0]  in_op;
    logic [61:0] in_num, in_time, in_largest, in_first, in_gap, in_rlen;
    logic [15:0] in_len;
    logic        in_infl;
    logic [31:0] in_rtt;

    assign in_op      = s_axis_tuser;
    assign in_num     = s_axis_tdata[61:0];
    assign in_time    = s_axis_tdata[123:62];
    assign in_len     = s_axis_tdata[139:124];
    assign in_infl    = s_axis_tdata[140];
    assign in_rtt     = s_axis_tdata[172:141];
    assign in_largest = s_axis_tdata[234:173];
    assign in_first   = s_axis_tdata[296:235];
    assign in_gap     = s_axis_tdata[358:297];
    assign in_rlen    = s_axis_tdata[420:359];

    logic              accept, out_free, scan_done;
    logic [SLOT_W-1:0] rd_addr;
    logic              ram_we;
    t_entry            wr_entry, rd_entry;
    logic [$bits(t_entry)-1:0] ram_rdata;

    // first free slot
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
    always_comb begin
        free_ok   = 1'b0;
        free_slot = '0;
        for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_ok   = 1'b1;
                free_slot = SLOT_W'(s);
            end
        end
    end

    logic tbl_full;
    assign tbl_full = (r_tracked >= CNT_W'(TABLE_DEPTH)) || !free_ok;

    assign wr_entry = '{cnt: in_infl, len: in_len, tm: in_time, num: in_num};
    assign ram_we   = accept && !r_dropped && (in_op == OP_REC) && !tbl_full;

    spalt_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_slot),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );
    assign rd_entry = t_entry'(ram_rdata);

    // compare stage on the word read last cycle
    logic        is_scan, slot_ok, hit, better, dl_cand;
    logic [62:0] dl_val;
    always_comb begin
        is_scan = (r_op == OP_SCAN);
        slot_ok = r_chk && r_valid[r_chk_slot];
        hit     = slot_ok && (is_scan ? (rd_entry.tm < r_lo)
                                      : (rd_entry.num >= r_lo && rd_entry.num <= r_hi));
        better  = !r_have || (rd_entry.num < r_best_num);
        dl_cand = is_scan && r_first_pass && slot_ok && !(rd_entry.tm < r_lo);
        dl_val  = {1'b0, rd_entry.tm} + 63'(r_delay);
    end

    // outputs of the controller
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        out_free      = !r_ov || m_axis_tready;
        rd_addr       = r_idx[SLOT_W-1:0];
        scan_done     = (r_state == S_SCAN) && (r_idx == CNT_W'(TABLE_DEPTH)) && !r_chk;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (r_dropped) begin
                        n_state = S_CLOSE;
                    end else begin
                        case (in_op)
                            OP_ACK1: n_state = S_PREP3;
                            OP_ACK2: n_state = S_PREP1;
                            OP_SCAN: n_state = S_PREP1;
                            default: n_state = S_CLOSE;
                        endcase
                    end
                end
            end
            S_PREP1: n_state = S_PREP2;
            S_PREP2: n_state = S_PREP3;
            S_PREP3: n_state = S_SCAN;
            S_SCAN:  if (scan_done) n_state = r_have ? S_EMIT : S_CLOSE;
            S_EMIT:  if (out_free) n_state = S_SCAN;
            S_CLOSE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [22:0] add_sum;
    logic [21:0] sub_unacked;
    logic [61:0] lo_ack;
    logic        word_load;
    assign add_sum     = {1'b0, r_unacked} + {7'd0, in_len};
    assign sub_unacked = (r_unacked > {6'd0, r_best_len}) ? (r_unacked - {6'd0, r_best_len})
                                                          : 22'd0;
    assign lo_ack      = sat_sub(r_hi, r_len_arg);
    assign word_load   = out_free && (r_state == S_EMIT || r_state == S_CLOSE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mult     <= 5'd9;
            r_min      <= 32'd500000;
            r_valid    <= '0;
            r_tracked  <= '0;
            r_unacked  <= '0;
            r_earliest <= '0;
            r_dropped  <= 1'b0;
            r_cursor   <= '0;
            r_ov       <= 1'b0;
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RTT_MULT:  r_mult <= i_cfg_wdata[4:0];
                    REG_MIN_DELAY: r_min  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (m_axis_tready && !word_load) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op         <= in_op;
                        r_now        <= in_time;
                        r_rtt        <= in_rtt;
                        r_arg        <= in_gap;
                        r_close_kind <= r_dropped ? KIND_IGN
                                      : ((in_op == OP_REC) && tbl_full) ? KIND_FULL
                                      : KIND_DONE;
                        r_hi         <= (in_op == OP_ACK1) ? in_largest : r_cursor;
                        r_len_arg    <= (in_op == OP_ACK1) ? in_first : in_rlen;
                        if (r_dropped) begin
                        end else if (in_op == OP_REC) begin
                            if (!tbl_full) begin
                                r_valid[free_slot] <= 1'b1;
                                r_tracked <= r_tracked + CNT_W'(1);
                                if (in_infl) begin
                                    r_unacked <= (add_sum > {1'b0, BYTES_MAX}) ? BYTES_MAX
                                                                              : add_sum[21:0];
                                end
                            end
                        end else if (in_op == OP_DROP) begin
                            r_valid    <= '0;
                            r_tracked  <= '0;
                            r_unacked  <= '0;
                            r_earliest <= '0;
                            r_cursor   <= '0;
                            r_dropped  <= 1'b1;
                        end
                    end
                end
                S_PREP1: begin
                    if (is_scan) r_prod <= {5'd0, r_rtt} * {32'd0, r_mult};
                    else         r_hi   <= sat_sub(r_hi, r_arg);
                end
                S_PREP2: begin
                    if (is_scan) begin
                        if (r_prod < DELAY_FLOOR && {5'd0, r_min} < DELAY_FLOOR)
                            r_delay <= DELAY_FLOOR;
                        else if (r_prod < {5'd0, r_min})
                            r_delay <= {5'd0, r_min};
                        else
                            r_delay <= r_prod;
                    end else begin
                        r_hi <= sat_sub(r_hi, GAP_BIAS);
                    end
                end
                S_PREP3: begin
                    if (is_scan) begin
                        r_lo <= sat_sub(r_now, {25'd0, r_delay});
                    end else begin
                        r_lo     <= lo_ack;
                        r_cursor <= lo_ack;
                    end
                    r_idx        <= '0;
                    r_chk        <= 1'b0;
                    r_have       <= 1'b0;
                    r_first_pass <= 1'b1;
                    r_dl_have    <= 1'b0;
                end
                S_SCAN: begin
                    if (r_idx != CNT_W'(TABLE_DEPTH)) begin
                        r_idx      <= r_idx + CNT_W'(1);
                        r_chk      <= 1'b1;
                        r_chk_slot <= r_idx[SLOT_W-1:0];
                    end else begin
                        r_chk <= 1'b0;
                    end
                    if (hit && better) begin
                        r_have      <= 1'b1;
                        r_best_slot <= r_chk_slot;
                        r_best_num  <= rd_entry.num;
                        r_best_len  <= rd_entry.len;
                        r_best_cnt  <= rd_entry.cnt;
                    end
                    if (dl_cand && (!r_dl_have || dl_val < r_dl_best)) begin
                        r_dl_have <= 1'b1;
                        r_dl_best <= dl_val;
                    end
                    if (scan_done) begin
                        r_first_pass <= 1'b0;
                        if (is_scan && r_first_pass)
                            r_earliest <= r_dl_have ? r_dl_best : 63'd0;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_valid[r_best_slot] <= 1'b0;
                        if (r_tracked != '0) r_tracked <= r_tracked - CNT_W'(1);
                        if (r_best_cnt) r_unacked <= sub_unacked;
                        r_ov         <= 1'b1;
                        r_o_kind     <= is_scan ? KIND_LOST : KIND_ACKED;
                        r_o_num      <= r_best_num;
                        r_o_len      <= r_best_len;
                        r_o_infl     <= r_best_cnt;
                        r_o_unacked  <= r_best_cnt ? sub_unacked : r_unacked;
                        r_o_deadline <= r_earliest;
                        r_o_tracked  <= (r_tracked != '0) ? r_tracked - CNT_W'(1) : r_tracked;
                        r_o_last     <= 1'b0;
                        r_idx        <= '0;
                        r_chk        <= 1'b0;
                        r_have       <= 1'b0;
                    end
                end
                S_CLOSE: begin
                    if (out_free) begin
                        r_ov         <= 1'b1;
                        r_o_kind     <= r_close_kind;
                        r_o_num      <= '0;
                        r_o_len      <= '0;
                        r_o_infl     <= 1'b0;
                        r_o_unacked  <= r_unacked;
                        r_o_deadline <= r_earliest;
                        r_o_tracked  <= r_tracked;
                        r_o_last     <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {5'd0, 7'(r_o_tracked), r_o_deadline, r_o_unacked, r_o_infl,
                            r_o_len, r_o_num};

    `SPALT_ASSERT(a_trk_max, i_clk, i_rst_n, r_tracked <= CNT_W'(TABLE_DEPTH), "count above depth")
    `SPALT_ASSERT(a_trk_pop, i_clk, i_rst_n, $countones(r_valid) == int'(r_tracked), "count vs valid bits")
    `SPALT_ASSERT_NEXT(a_drop_hold, i_clk, i_rst_n, r_dropped, r_dropped && r_tracked == '0, "drop not held")
    `SPALT_ASSERT_NEXT(a_emit_word, i_clk, i_rst_n, r_state == S_EMIT && out_free, r_ov && !r_o_last, "retire word missing")
endmodule

// ----- rtl/core/spalt_ram.sv -----
`timescale 1ns / 1ps
module spalt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
